@@ rtl/rrps_pkg.sv @@
`timescale 1ns / 1ps
package rrps_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CLK_W = 48;

  // command codes
  localparam logic [1:0] CMD_LAUNCH   = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_REPORT   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_QUANTUM  = 3'd0;
  localparam logic [2:0] REG_BLK_WAIT = 3'd1;
  localparam logic [2:0] REG_INTERVAL = 3'd2;
  localparam logic [2:0] REG_LIMIT    = 3'd3;
  localparam logic [2:0] REG_MAX_SIM  = 3'd4;
  localparam logic [2:0] REG_IDLE     = 3'd5;

  typedef struct packed {
    logic occ;
    logic act;
    logic rdy;
    logic blk;
  } slot_st_t;

  // update broadcast to the cell row
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             launch;
    logic             set_rdy;
    logic             clr_rdy;
    logic             set_blk;
    logic             clr_blk;
    logic             clr_act;
  } cell_cmd_t;

  // priority token passed cell to cell
  typedef struct packed {
    logic free_seen;
    logic inact_seen;
  } chain_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CLK_W-1:0] wake;
  } blk_ent_t;

endpackage

@@ rtl/rrps_slot_cell.sv @@
`timescale 1ns / 1ps
module rrps_slot_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [rrps_pkg::IDX_W-1:0] cell_idx,
  input  rrps_pkg::cell_cmd_t      cmd,
  input  rrps_pkg::chain_t         chain_in,
  output rrps_pkg::chain_t         chain_out,
  output rrps_pkg::slot_st_t       st,
  output logic                     pick_free,
  output logic                     pick_inact
);
  import rrps_pkg::*;

  logic sel;
  assign sel = (cmd.idx == cell_idx);

  // status flags of this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (sel) begin
      if (cmd.launch) begin
        st <= '{occ: 1'b1, act: 1'b1, rdy: 1'b1, blk: 1'b0};
      end else begin
        if (cmd.set_rdy) st.rdy <= 1'b1;
        if (cmd.clr_rdy) st.rdy <= 1'b0;
        if (cmd.set_blk) st.blk <= 1'b1;
        if (cmd.clr_blk) st.blk <= 1'b0;
        if (cmd.clr_act) st.act <= 1'b0;
      end
    end
  end

  // first-free and first-inactive token
  assign pick_free            = !st.occ && !chain_in.free_seen;
  assign pick_inact           = !st.act && !chain_in.inact_seen;
  assign chain_out.free_seen  = chain_in.free_seen || !st.occ;
  assign chain_out.inact_seen = chain_in.inact_seen || !st.act;

endmodule

@@ rtl/rrps_blk_queue.sv @@
`timescale 1ns / 1ps
module rrps_blk_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rrps_pkg::blk_ent_t        push_data,
  input  logic                      pop,
  output rrps_pkg::blk_ent_t        head_data,
  output logic [rrps_pkg::CNT_W-1:0] cnt
);
  import rrps_pkg::*;

  blk_ent_t         mem [SLOTS];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;

  assign head_data = mem[head];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && (pop || cnt != CNT_W'(SLOTS))) mem[tail] <= push_data;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (pop) head <= (head == IDX_W'(SLOTS - 1)) ? '0 : head + 1'b1;
      if (push && (pop || cnt != CNT_W'(SLOTS)))
        tail <= (tail == IDX_W'(SLOTS - 1)) ? '0 : tail + 1'b1;
      if (push && !pop && cnt != CNT_W'(SLOTS)) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/round_robin_process_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Sequence: launch and report run an execute state, then a finish state; a report that
// blocks adds a push to the blocked queue; a dispatch scans each queued blocked slot first.
// Commands are taken one at a time; the blocked-queue scan sets dispatch time.
// A new command is taken while the previous result still waits at the output.
// Reset (rst, synchronous, active high) clears clock, counters, slot flags and
// both queues and loads the register defaults; no clearing pass is needed.
module round_robin_process_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [33:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  slot,
  input  logic [29:0] used_ns,
  input  logic        finished,
  input  logic [33:0] burst_ns,
  input  logic [15:0] overhead_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        granted,
  output logic [7:0]  out_slot,
  output logic [29:0] grant_ns,
  output logic [47:0] clock_ns,
  output logic        all_done
);
  import rrps_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_REP2, S_SCAN, S_DISP, S_FIN} state_t;

  state_t state;

  // configuration
  logic [29:0] quantum, blk_wait, idle_step;
  logic [33:0] interval;
  logic [15:0] limit;
  logic [8:0]  max_sim;

  // scheduler state
  logic [CLK_W-1:0] sim_clock, next_launch;
  logic [15:0]      launched;
  logic [8:0]       active;
  logic [CNT_W-1:0] scan_n;

  // captured command
  logic [1:0]  cmd_r;
  logic [7:0]  slot_r;
  logic [29:0] used_r;
  logic        fin_r;
  logic [15:0] ovh_r;

  // pending result
  logic        res_granted;
  logic [7:0]  res_slot;
  logic [29:0] res_grant;

  // ready queue
  logic [IDX_W-1:0] rf_mem [SLOTS];
  logic [IDX_W-1:0] rf_head, rf_tail;
  logic [CNT_W-1:0] rf_cnt;
  logic             rf_push, rf_pop;
  logic [IDX_W-1:0] rf_push_idx;

  // blocked queue
  logic             bq_push, bq_pop;
  blk_ent_t         bq_push_data, bq_head;
  logic [CNT_W-1:0] bq_cnt;

  // cell row
  cell_cmd_t        cc;
  chain_t           chain [SLOTS+1];
  slot_st_t         st [SLOTS];
  logic [SLOTS-1:0] pf, pi;

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rrps_slot_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cc),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .st        (st[g]),
      .pick_free (pf[g]),
      .pick_inact(pi[g])
    );
  end

  rrps_blk_queue u_bq (
    .clk      (clk),
    .rst      (rst),
    .push     (bq_push),
    .push_data(bq_push_data),
    .pop      (bq_pop),
    .head_data(bq_head),
    .cnt      (bq_cnt)
  );

  // launch slot choice: first unoccupied, else first inactive
  logic [IDX_W-1:0] free_idx, inact_idx, pick_idx;
  logic             pick_any;
  always_comb begin
    free_idx  = '0;
    inact_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pf[i]) free_idx  = free_idx  | IDX_W'(i);
      if (pi[i]) inact_idx = inact_idx | IDX_W'(i);
    end
    pick_idx = chain[SLOTS].free_seen ? free_idx : inact_idx;
    pick_any = chain[SLOTS].free_seen || chain[SLOTS].inact_seen;
  end

  // decisions
  logic [IDX_W-1:0] rep_idx;
  slot_st_t         rep_st, scan_st;
  logic             launch_ok, rep_ok, expired;
  assign rep_idx   = slot_r[IDX_W-1:0];
  assign rep_st    = st[rep_idx];
  assign scan_st   = st[bq_head.idx];
  assign expired   = (sim_clock >= bq_head.wake);
  assign launch_ok = (launched < limit) && (active < max_sim) &&
                     (sim_clock >= next_launch) && pick_any;
  assign rep_ok    = ({1'b0, slot_r} < 9'(SLOTS)) && rep_st.act && !rep_st.rdy &&
                     !rep_st.blk;

  // cell and queue controls
  always_comb begin
    cc           = '0;
    rf_push      = 1'b0;
    rf_pop       = 1'b0;
    rf_push_idx  = '0;
    bq_push      = 1'b0;
    bq_pop       = 1'b0;
    bq_push_data = bq_head;
    unique case (state)
      S_EXEC: begin
        if (cmd_r == CMD_LAUNCH && launch_ok) begin
          cc.idx      = pick_idx;
          cc.launch   = 1'b1;
          rf_push     = 1'b1;
          rf_push_idx = pick_idx;
        end else if (cmd_r == CMD_REPORT && rep_ok) begin
          cc.idx = rep_idx;
          if (fin_r) begin
            cc.clr_act = 1'b1;
          end else if (used_r == quantum) begin
            cc.set_rdy  = 1'b1;
            rf_push     = 1'b1;
            rf_push_idx = rep_idx;
          end else begin
            cc.set_blk = 1'b1;
          end
        end
      end
      S_REP2: begin
        bq_push           = 1'b1;
        bq_push_data.idx  = rep_idx;
        bq_push_data.wake = sim_clock + CLK_W'(blk_wait);
      end
      S_SCAN: begin
        if (scan_n != '0) begin
          bq_pop = 1'b1;
          if (expired) begin
            cc.idx     = bq_head.idx;
            cc.clr_blk = 1'b1;
            if (!scan_st.rdy) begin
              cc.set_rdy  = 1'b1;
              rf_push     = 1'b1;
              rf_push_idx = bq_head.idx;
            end
          end else begin
            bq_push = 1'b1;
          end
        end
      end
      S_DISP: begin
        if (rf_cnt != '0) begin
          rf_pop     = 1'b1;
          cc.idx     = rf_mem[rf_head];
          cc.clr_rdy = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ready queue storage
  always_ff @(posedge clk) begin
    if (rf_push && rf_cnt != CNT_W'(SLOTS)) rf_mem[rf_tail] <= rf_push_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_head <= '0;
      rf_tail <= '0;
      rf_cnt  <= '0;
    end else begin
      if (rf_pop) begin
        rf_head <= (rf_head == IDX_W'(SLOTS - 1)) ? '0 : rf_head + 1'b1;
        rf_cnt  <= rf_cnt - 1'b1;
      end else if (rf_push && rf_cnt != CNT_W'(SLOTS)) begin
        rf_tail <= (rf_tail == IDX_W'(SLOTS - 1)) ? '0 : rf_tail + 1'b1;
        rf_cnt  <= rf_cnt + 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum   <= 30'd25000000;
      blk_wait  <= 30'd10000000;
      interval  <= 34'd200000000;
      limit     <= 16'd15;
      max_sim   <= 9'd7;
      idle_step <= 30'd10000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUANTUM:  quantum   <= cfg_data[29:0];
        REG_BLK_WAIT: blk_wait  <= cfg_data[29:0];
        REG_INTERVAL: interval  <= cfg_data;
        REG_LIMIT:    limit     <= cfg_data[15:0];
        REG_MAX_SIM:  max_sim   <= cfg_data[8:0];
        REG_IDLE:     idle_step <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sim_clock   <= '0;
      next_launch <= '0;
      launched    <= '0;
      active      <= '0;
      scan_n      <= '0;
      out_valid   <= 1'b0;
    end else begin
      // beat taken; a new beat in S_FIN sets valid again
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= cmd;
            slot_r      <= slot;
            used_r      <= used_ns;
            fin_r       <= finished;
            ovh_r       <= overhead_ns;
            res_granted <= 1'b0;
            res_slot    <= '0;
            res_grant   <= '0;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
          unique case (cmd_r)
            CMD_LAUNCH: begin
              if (launch_ok) begin
                launched    <= launched + 1'b1;
                active      <= active + 1'b1;
                next_launch <= sim_clock + CLK_W'(interval);
                sim_clock   <= sim_clock + CLK_W'(ovh_r);
                res_granted <= 1'b1;
                res_slot    <= 8'(pick_idx);
              end
            end
            CMD_DISPATCH: begin
              scan_n <= bq_cnt;
              state  <= S_SCAN;
            end
            CMD_REPORT: begin
              if (rep_ok) begin
                sim_clock <= sim_clock + CLK_W'(used_r);
                if (fin_r) begin
                  if (active != '0) active <= active - 1'b1;
                end else if (used_r != quantum) begin
                  state <= S_REP2;
                end
              end
            end
            default: ;
          endcase
        end
        S_REP2: state <= S_FIN;
        S_SCAN: begin
          if (scan_n == '0) state <= S_DISP;
          else scan_n <= scan_n - 1'b1;
        end
        S_DISP: begin
          if (rf_cnt == '0) begin
            sim_clock <= sim_clock + CLK_W'(idle_step);
          end else begin
            sim_clock   <= sim_clock + CLK_W'(ovh_r);
            res_granted <= 1'b1;
            res_slot    <= 8'(rf_mem[rf_head]);
            res_grant   <= quantum;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            granted   <= res_granted;
            out_slot  <= res_slot;
            grant_ns  <= res_grant;
            clock_ns  <= sim_clock;
            all_done  <= (launched >= limit) && (active == '0);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/round_robin_process_scheduler_unit_test.sv @@
`timescale 1ns / 1ps
module round_robin_process_scheduler_unit_test;
  import rrps_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic [29:0] used_ns;
    logic        finished;
    logic [33:0] burst_ns;
    logic [15:0] overhead_ns;
  } sched_cmd_t;

  typedef struct packed {
    logic        granted;
    logic [7:0]  out_slot;
    logic [29:0] grant_ns;
    logic [47:0] clock_ns;
    logic        all_done;
  } sched_res_t;

  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [33:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic [7:0] slot = '0;
  logic [29:0] used_ns = '0;
  logic finished = 1'b0;
  logic [33:0] burst_ns = '0;
  logic [15:0] overhead_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic granted;
  logic [7:0] out_slot;
  logic [29:0] grant_ns;
  logic [47:0] clock_ns;
  logic all_done;

  round_robin_process_scheduler_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler shadow state
  logic [29:0] q_quantum, q_blk_wait, q_idle;
  logic [33:0] q_interval;
  logic [15:0] q_limit;
  logic [8:0]  q_max_sim;
  logic [47:0] s_clock, s_next_launch;
  logic [15:0] s_launched;
  logic [8:0]  s_active;
  slot_st_t    s_st [SLOTS];
  logic [47:0] s_wake [SLOTS];
  int ready_q[$];
  int blocked_q[$];

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_res[$];
  int errors = 0;
  int mismatches = 0;
  int sent = 0;
  int last_cmd = 0;
  bit rx_hold = 1'b0;
  bit no_idle = 1'b0;

  function automatic void model_reset();
    q_quantum = 30'd25000000;
    q_blk_wait = 30'd10000000;
    q_interval = 34'd200000000;
    q_limit = 16'd15;
    q_max_sim = 9'd7;
    q_idle = 30'd10000000;
    s_clock = '0;
    s_next_launch = '0;
    s_launched = '0;
    s_active = '0;
    for (int i = 0; i < SLOTS; i++) begin
      s_st[i] = '0;
      s_wake[i] = '0;
    end
    ready_q.delete();
    blocked_q.delete();
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [33:0] val);
    case (idx)
      REG_QUANTUM:  q_quantum = val[29:0];
      REG_BLK_WAIT: q_blk_wait = val[29:0];
      REG_INTERVAL: q_interval = val;
      REG_LIMIT:    q_limit = val[15:0];
      REG_MAX_SIM:  q_max_sim = val[8:0];
      REG_IDLE:     q_idle = val[29:0];
      default: ;
    endcase
  endfunction

  function automatic void queue_ready(int s);
    if (!s_st[s].rdy) begin
      s_st[s].rdy = 1'b1;
      ready_q.push_back(s);
    end
  endfunction

  // compute the result of one command and advance the shadow state
  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    int pick;
    int n;
    int j;
    r = '0;
    if (c.cmd == CMD_LAUNCH) begin
      pick = -1;
      if (s_launched < q_limit && s_active < q_max_sim && s_clock >= s_next_launch) begin
        for (int s = 0; s < SLOTS && pick < 0; s++) if (!s_st[s].occ) pick = s;
        for (int s = 0; s < SLOTS && pick < 0; s++) if (!s_st[s].act) pick = s;
      end
      if (pick >= 0) begin
        s_st[pick] = '0;
        s_st[pick].occ = 1'b1;
        s_st[pick].act = 1'b1;
        s_wake[pick] = '0;
        s_launched++;
        s_active++;
        s_next_launch = s_clock + 48'(q_interval);
        queue_ready(pick);
        s_clock = s_clock + 48'(c.overhead_ns);
        r.granted = 1'b1;
        r.out_slot = 8'(pick);
      end
    end else if (c.cmd == CMD_DISPATCH) begin
      n = blocked_q.size();
      for (int k = 0; k < n; k++) begin
        j = blocked_q.pop_front();
        if (s_clock >= s_wake[j]) begin
          s_st[j].blk = 1'b0;
          queue_ready(j);
        end else begin
          blocked_q.push_back(j);
        end
      end
      if (ready_q.size() == 0) begin
        s_clock = s_clock + 48'(q_idle);
      end else begin
        j = ready_q.pop_front();
        s_st[j].rdy = 1'b0;
        s_clock = s_clock + 48'(c.overhead_ns);
        r.granted = 1'b1;
        r.out_slot = 8'(j);
        r.grant_ns = q_quantum;
      end
    end else if (c.cmd == CMD_REPORT) begin
      j = c.slot;
      if (j < SLOTS && s_st[j].act && !s_st[j].rdy && !s_st[j].blk) begin
        s_clock = s_clock + 48'(c.used_ns);
        if (c.finished) begin
          s_st[j].act = 1'b0;
          if (s_active > 0) s_active--;
        end else if (c.used_ns == q_quantum) begin
          queue_ready(j);
        end else begin
          s_st[j].blk = 1'b1;
          s_wake[j] = s_clock + 48'(q_blk_wait);
          blocked_q.push_back(j);
        end
      end
    end
    r.clock_ns = s_clock;
    r.all_done = (s_launched >= q_limit) && (s_active == 0);
    return r;
  endfunction

  function automatic sched_cmd_t rand_cmd(int kind);
    sched_cmd_t c;
    c.cmd = 2'(kind);
    c.slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOTS - 1));
    case ($urandom_range(0, 3))
      0: c.used_ns = 30'($urandom);
      1: c.used_ns = q_quantum;
      default: c.used_ns = 30'($urandom_range(0, 2000));
    endcase
    c.finished = ($urandom_range(0, 3) == 0);
    c.burst_ns = {2'($urandom), 32'($urandom)};
    c.overhead_ns = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) sent <= sent + 1;
      if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 24)) begin
        sched_cmd_t c;
        c = pending_cmds.pop_front();
        expected_res.push_back(schedule_step(c));
        in_valid <= 1'b1;
        cmd <= c.cmd;
        slot <= c.slot;
        used_ns <= c.used_ns;
        finished <= c.finished;
        burst_ns <= c.burst_ns;
        overhead_ns <= c.overhead_ns;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sched_res_t got, exp;
        got = {granted, out_slot, grant_ns, clock_ns, all_done};
        if (expected_res.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result beat %h", got);
        end else begin
          exp = expected_res.pop_front();
          if (got !== exp) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp g=%0b s=%0d q=%0d c=%0d d=%0b got g=%0b s=%0d q=%0d c=%0d d=%0b",
                       exp.granted, exp.out_slot, exp.grant_ns, exp.clock_ns, exp.all_done,
                       got.granted, got.out_slot, got.grant_ns, got.clock_ns, got.all_done);
          end
        end
      end
      out_ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 24);
    end
  end

  // cycle limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (20 + 2 * SLOTS) @(posedge clk);
  endtask

  // one register write as a one-cycle enable strobe; the enable is low on return
  task automatic write_reg(logic [2:0] idx, logic [33:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(idx, val);
    @(posedge clk);
  endtask

  // session: launches, dispatches, reports for slot last_cmd (stepped mod 8 per dispatch), random commands
  task automatic add_session(int len);
    sched_cmd_t c;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: c = rand_cmd(CMD_LAUNCH);
        3, 4, 5: c = rand_cmd(CMD_DISPATCH);
        9: c = rand_cmd($urandom_range(0, 3));
        default: begin
          c = rand_cmd(CMD_REPORT);
          c.slot = 8'(last_cmd);
        end
      endcase
      if (c.cmd == CMD_DISPATCH) last_cmd = (last_cmd + 1) % 8;
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    sched_cmd_t c;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, extremes of fields, each command, invalid command
    c = '0; c.burst_ns = '1; c.overhead_ns = '1; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_LAUNCH; c.burst_ns = '0; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_DISPATCH; c.overhead_ns = '1; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_REPORT; c.slot = 8'd0; c.used_ns = 30'd25000000;
    pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_DISPATCH; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_REPORT; c.slot = 8'd0; c.used_ns = 30'd5; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_REPORT; c.slot = 8'hff; c.used_ns = '1; c.finished = 1'b1;
    pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_DISPATCH; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_DISPATCH; pending_cmds.push_back(c);
    c = '0; c.cmd = 2'd3; c = ~c; c.cmd = 2'd3; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_REPORT; c.slot = 8'd0; c.used_ns = '1; c.finished = 1'b1;
    pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_DISPATCH; pending_cmds.push_back(c);
    c = '0; c.cmd = CMD_REPORT; c.slot = 8'd0; c.used_ns = '1; c.finished = 1'b1;
    pending_cmds.push_back(c);
    wait_drained();

    // phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_INTERVAL, 34'd0);
          write_reg(REG_LIMIT, 16'd40);
          write_reg(REG_MAX_SIM, 9'd256);
          write_reg(REG_QUANTUM, 30'd1000);
          write_reg(REG_BLK_WAIT, 30'd0);
          write_reg(REG_IDLE, 30'd0);
        end
        1: begin
          write_reg(REG_QUANTUM, 30'd1);
          write_reg(REG_BLK_WAIT, 30'd3000);
          write_reg(REG_IDLE, 30'd500);
          write_reg(REG_LIMIT, 16'd65535);
        end
        2: begin
          write_reg(REG_QUANTUM, '1);
          write_reg(REG_BLK_WAIT, '1);
          write_reg(REG_IDLE, '1);
          write_reg(REG_INTERVAL, '1);
          write_reg(REG_MAX_SIM, 9'd1);
        end
        3: begin
          write_reg(REG_INTERVAL, 34'd100);
          write_reg(REG_MAX_SIM, 9'd4);
          write_reg(REG_QUANTUM, 30'd1500);
          write_reg(REG_BLK_WAIT, 30'd800);
          write_reg(REG_IDLE, 30'd300);
          write_reg(REG_LIMIT, 16'd0);
        end
        4: begin
          write_reg(REG_LIMIT, 16'hffff);
          write_reg(REG_MAX_SIM, 9'd16);
          write_reg(REG_INTERVAL, 34'd0);
        end
        default: begin
          write_reg(REG_MAX_SIM, 9'($urandom_range(1, 20)));
          write_reg(REG_QUANTUM, 30'($urandom_range(1, 2000)));
          write_reg(REG_BLK_WAIT, 30'($urandom_range(0, 3000)));
          write_reg(REG_INTERVAL, 34'($urandom_range(0, 500)));
        end
      endcase
      no_idle = (ph == 4);
      add_session(100);
      if (ph == 2) begin
        // receiver holds off while commands keep coming
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
